/* hw/rtl/cic_pkg.sv */
// Shared constants, codes and types of the choppiness index classifier.
// No dependencies; every other file of the block but cic_ram imports it.
`timescale 1ns / 1ps

package cic_pkg;

  localparam int MAX_PERIOD_DEF  = 64;
  localparam int PRICE_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PERIOD_W   = 7;
  localparam int THR_W      = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOPPY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRENDING = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST   = 7'd14;
  localparam logic [THR_W-1:0]    CHOPPY_RST   = 16'd15821;  // 61.8
  localparam logic [THR_W-1:0]    TRENDING_RST = 16'd9779;   // 38.2

  // Q8.8 index
  localparam int IDX_W = 16;
  localparam logic [IDX_W-1:0] CHOP_HALF = 16'd12800;  // 50.0
  localparam logic [IDX_W-1:0] CHOP_MAX  = 16'd51200;  // 200.0

  // log2 unit
  localparam int MANT_W   = 32;
  localparam int LOG_FRAC = 16;

  typedef enum logic [1:0] {
    MC_NEUTRAL      = 2'd0,
    MC_CHOPPY       = 2'd1,
    MC_TRENDING     = 2'd2,
    MC_TRANSITIONAL = 2'd3
  } market_class_e;

endpackage

/* hw/rtl/cic_bar_if.sv */
// Valid/ready channel that carries one price bar per word.
// Depends on cic_pkg for the default price width.
`timescale 1ns / 1ps

interface cic_bar_if import cic_pkg::*; #(
  parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] bar_high;
  logic [PRICE_WIDTH-1:0] bar_low;
  logic [PRICE_WIDTH-1:0] bar_close;

  modport source (output valid, bar_high, bar_low, bar_close, input ready);
  modport sink   (input valid, bar_high, bar_low, bar_close, output ready);
endinterface

/* hw/rtl/cic_res_if.sv */
// Valid/ready channel that carries one index result per word.
// Depends on cic_pkg for widths.
`timescale 1ns / 1ps

interface cic_res_if import cic_pkg::*;;
  logic             valid;
  logic             ready;
  logic             index_valid;
  logic [IDX_W-1:0] index_value;
  logic [1:0]       market_class;

  modport source (output valid, index_valid, index_value, market_class, input ready);
  modport sink   (input valid, index_valid, index_value, market_class, output ready);
endinterface

/* hw/rtl/cic_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/cic_log2.sv */
// Fixed-point log2 unit: bit-serial normalize, then one mantissa squaring per
// fraction bit. Depends on cic_pkg.
`timescale 1ns / 1ps

module cic_log2 import cic_pkg::*; #(
  parameter int XW = 38,
  parameter int NW = $clog2(XW)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [XW-1:0]          x_i,
  output logic                   done_o,
  output logic [NW+LOG_FRAC-1:0] lg_o
);
  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQ   = 2'd2;
  localparam int CW = $clog2(LOG_FRAC);

  logic [1:0]          state_q, state_d;
  logic [XW-1:0]       x_q, x_d;
  logic [NW-1:0]       n_q, n_d;
  logic [MANT_W-1:0]   m_q, m_d;
  logic [LOG_FRAC-1:0] frac_q, frac_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_t;

  assign sq   = m_q * m_q;
  assign sq_t = sq[2*MANT_W-1 -: MANT_W+1];

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    n_d     = n_q;
    m_d     = m_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (start_i) begin
          x_d     = x_i;
          n_d     = NW'(XW - 1);
          state_d = L_NORM;
        end
      end
      L_NORM: begin
        if (x_q[XW-1] || n_q == '0) begin
          m_d     = x_q[XW-1 -: MANT_W];
          cnt_d   = '0;
          state_d = L_SQ;
        end else begin
          x_d = {x_q[XW-2:0], 1'b0};
          n_d = n_q - 1'b1;
        end
      end
      L_SQ: begin
        // square, then halve back into [1,2) when it overflowed
        if (sq_t[MANT_W]) begin
          m_d    = sq_t[MANT_W:1];
          frac_d = {frac_q[LOG_FRAC-2:0], 1'b1};
        end else begin
          m_d    = sq_t[MANT_W-1:0];
          frac_d = {frac_q[LOG_FRAC-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(LOG_FRAC - 1)) begin
          done_d  = 1'b1;
          state_d = L_IDLE;
        end
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    n_q    <= n_d;
    m_q    <= m_d;
    frac_q <= frac_d;
  end

  assign done_o = done_q;
  assign lg_o   = {n_q, frac_q};
endmodule

/* hw/rtl/choppiness_index_classifier.sv */
// Choppiness index classifier top level: bar window RAM, scan, log and
// divide sequencer. Depends on cic_pkg, cic_bar_if, cic_res_if, cic_ram, cic_log2.
`timescale 1ns / 1ps

// One price bar per input word, one result word per bar, one bar in flight.
// A warm-up bar goes from idle straight to the final state, where its result
// is loaded into the output register once that register is free. A full bar
// scans the window out of the bar RAM; unless the window is flat, it then
// takes three log2 runs on the shared log unit (sum, high-low range, P), each
// a bit-serial normalize (one shift per cycle, then a load; the sum is SUM_W =
// PRICE_WIDTH + log2 MAX_PERIOD bits wide) plus one squaring per fraction bit
// and a registered done, and then, when the log of the sum exceeds that of the
// range, a restoring divide of one quotient bit per cycle. A new bar is
// accepted while the last result still waits on the output register.
// Configuration writes go through cfg_we_i/cfg_idx_i/cfg_wdata_i and should
// land only while the block is idle.
module choppiness_index_classifier import cic_pkg::*; #(
  parameter int MAX_PERIOD  = MAX_PERIOD_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cic_bar_if.sink               bar_i,
  cic_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);
  localparam int PRICE_WIDTH = PRICE_WIDTH_DEF;
  localparam int IW    = $clog2(MAX_PERIOD);
  localparam int PCW   = $clog2(MAX_PERIOD + 1);
  localparam int BSW   = $clog2(MAX_PERIOD + 2);
  localparam int CW    = (PCW > PERIOD_W) ? PCW : PERIOD_W;
  localparam int SUM_W = PRICE_WIDTH + IW;
  localparam int XW    = (SUM_W > MANT_W) ? SUM_W : MANT_W;
  localparam int NW    = $clog2(XW);
  localparam int LG_W  = NW + LOG_FRAC;
  localparam int NUM_W = LG_W + 16;
  localparam int DCW   = $clog2(NUM_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LOG  = 3'd2;
  localparam logic [2:0] S_DIFF = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_CLMP = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // configuration
  logic [PERIOD_W-1:0] period_q;
  logic [THR_W-1:0]    chop_thr_q, trend_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_RST;
      chop_thr_q  <= CHOPPY_RST;
      trend_thr_q <= TRENDING_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:   period_q    <= cfg_wdata_i[PERIOD_W-1:0];
        REG_CHOPPY:   chop_thr_q  <= cfg_wdata_i[THR_W-1:0];
        REG_TRENDING: trend_thr_q <= cfg_wdata_i[THR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // state
  logic [2:0]             state_q, state_d;
  logic [PRICE_WIDTH-1:0] prev_close_q;
  logic [BSW-1:0]         bars_seen_q, bars_seen_d;
  logic [IW-1:0]          ptr_q, rp_q;
  logic [PCW-1:0]         p_q, issue_q;
  logic                   rv_q;
  logic [SUM_W-1:0]       sum_q;
  logic [PRICE_WIDTH-1:0] hi_q, lo_q;
  logic [1:0]             lsel_q;
  logic [LG_W-1:0]        lgs_q, lgr_q, lgp_q;
  logic [NUM_W-1:0]       num_q;
  logic [LG_W-1:0]        rem_q;
  logic [DCW-1:0]         dcnt_q;
  logic                   ivld_q;
  logic [IDX_W-1:0]       chop_q;
  logic                   out_vld_q;

  logic                   accept, issue, scan_end, flat, log_start, log_done, out_load;
  logic [CW-1:0]          per_ext, p_eff;
  logic [PRICE_WIDTH-1:0] tr, top, bot;
  logic [3*PRICE_WIDTH-1:0] rd_data;
  logic [PRICE_WIDTH-1:0] rd_tr, rd_hi, rd_lo;
  logic [XW-1:0]          log_x;
  logic [LG_W-1:0]        log_res, diff;
  logic [LG_W:0]          r2;
  logic                   qbit;
  market_class_e          cls;

  assign accept   = bar_i.valid && bar_i.ready;
  assign bar_i.ready = (state_q == S_IDLE);

  // clamp the period into 2..MAX_PERIOD
  assign per_ext = CW'(period_q);
  always_comb begin
    priority if (per_ext < CW'(2))                p_eff = CW'(2);
    else if (per_ext > CW'(MAX_PERIOD))           p_eff = CW'(MAX_PERIOD);
    else                                          p_eff = per_ext;
  end

  // true range against the previous close; zero on the first bar
  assign top = (bar_i.bar_high > prev_close_q) ? bar_i.bar_high : prev_close_q;
  assign bot = (bar_i.bar_low < prev_close_q) ? bar_i.bar_low : prev_close_q;
  assign tr  = (bars_seen_q != '0) ? top - bot : '0;

  assign bars_seen_d = (bars_seen_q < BSW'(MAX_PERIOD + 1)) ? bars_seen_q + 1'b1
                                                           : bars_seen_q;

  cic_ram #(
    .WIDTH(3 * PRICE_WIDTH),
    .DEPTH(MAX_PERIOD)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(ptr_q),
    .wdata_i({tr, bar_i.bar_high, bar_i.bar_low}),
    .raddr_i(rp_q),
    .rdata_o(rd_data)
  );
  assign {rd_tr, rd_hi, rd_lo} = rd_data;

  // window scan: one read issued per cycle, newest entry first
  assign issue    = (state_q == S_SCAN) && (issue_q != p_q);
  assign scan_end = (state_q == S_SCAN) && (issue_q == p_q) && !rv_q;
  assign flat     = (hi_q <= lo_q) || (sum_q == '0);

  // log unit feed: sum, then high-low range, then the period
  always_comb begin
    log_start = 1'b0;
    log_x     = XW'(sum_q);
    if (scan_end && !flat) begin
      log_start = 1'b1;
    end else if (state_q == S_LOG && log_done && lsel_q != 2'd2) begin
      log_start = 1'b1;
      log_x     = (lsel_q == 2'd0) ? XW'(hi_q - lo_q) : XW'(p_q);
    end
  end

  cic_log2 #(
    .XW(XW),
    .NW(NW)
  ) u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(log_start),
    .x_i    (log_x),
    .done_o (log_done),
    .lg_o   (log_res)
  );

  // restoring divide step, one quotient bit per cycle
  assign diff = lgs_q - lgr_q;
  assign r2   = {rem_q, num_q[NUM_W-1]};
  assign qbit = (r2 >= (LG_W+1)'(lgp_q));

  // classify: choppy is tested before trending
  always_comb begin
    priority if (!ivld_q)            cls = MC_NEUTRAL;
    else if (chop_q >= chop_thr_q)   cls = MC_CHOPPY;
    else if (chop_q <= trend_thr_q)  cls = MC_TRENDING;
    else                             cls = MC_TRANSITIONAL;
  end

  assign out_load = (state_q == S_FIN) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = (bars_seen_d > BSW'(p_eff)) ? S_SCAN : S_FIN;
      S_SCAN: if (scan_end) state_d = flat ? S_FIN : S_LOG;
      S_LOG:  if (log_done && lsel_q == 2'd2) state_d = S_DIFF;
      S_DIFF: state_d = (lgs_q > lgr_q) ? S_DIV : S_FIN;
      S_DIV:  if (dcnt_q == DCW'(1)) state_d = S_CLMP;
      S_CLMP: state_d = S_FIN;
      S_FIN:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      prev_close_q <= '0;
      bars_seen_q  <= '0;
      ptr_q        <= '0;
      rv_q         <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      if (accept) begin
        prev_close_q <= bar_i.bar_close;
        bars_seen_q  <= bars_seen_d;
        ptr_q        <= (ptr_q == IW'(MAX_PERIOD - 1)) ? '0 : ptr_q + 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q     <= PCW'(p_eff);
      rp_q    <= ptr_q;
      issue_q <= '0;
      sum_q   <= '0;
      hi_q    <= '0;
      lo_q    <= '1;
      lsel_q  <= 2'd0;
      chop_q  <= '0;
      ivld_q  <= (bars_seen_d > BSW'(p_eff));
    end
    if (issue) begin
      issue_q <= issue_q + 1'b1;
      rp_q    <= (rp_q == '0) ? IW'(MAX_PERIOD - 1) : rp_q - 1'b1;
    end
    if (rv_q) begin
      sum_q <= sum_q + SUM_W'(rd_tr);
      if (rd_hi > hi_q) hi_q <= rd_hi;
      if (rd_lo < lo_q) lo_q <= rd_lo;
    end
    if (scan_end && flat) begin
      chop_q <= CHOP_HALF;
    end
    if (state_q == S_LOG && log_done) begin
      unique case (lsel_q)
        2'd0:    lgs_q <= log_res;
        2'd1:    lgr_q <= log_res;
        default: lgp_q <= log_res;
      endcase
      lsel_q <= lsel_q + 1'b1;
    end
    if (state_q == S_DIFF) begin
      // numerator D*25600 + lg(P)/2, with 25600 = (64+32+4) << 8
      num_q  <= (NUM_W'(diff) << 14) + (NUM_W'(diff) << 13) + (NUM_W'(diff) << 10)
                + NUM_W'(lgp_q >> 1);
      rem_q  <= '0;
      dcnt_q <= DCW'(NUM_W);
      if (lgs_q <= lgr_q) chop_q <= '0;
    end
    if (state_q == S_DIV) begin
      rem_q  <= qbit ? LG_W'(r2 - (LG_W+1)'(lgp_q)) : LG_W'(r2);
      num_q  <= {num_q[NUM_W-2:0], qbit};
      dcnt_q <= dcnt_q - 1'b1;
    end
    if (state_q == S_CLMP) begin
      chop_q <= (num_q > NUM_W'(CHOP_MAX)) ? CHOP_MAX : num_q[IDX_W-1:0];
    end
    if (out_load) begin
      res_o.index_valid  <= ivld_q;
      res_o.index_value  <= chop_q;
      res_o.market_class <= cls;
    end
  end

  assign res_o.valid = out_vld_q;

  a_bars_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bars_seen_q <= BSW'(MAX_PERIOD + 1))
    else $error("bar count ran past its saturation point");

  a_warm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.index_valid |->
      res_o.index_value == '0 && res_o.market_class == MC_NEUTRAL)
    else $error("warm-up word carries a nonzero index or class");

  a_index_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.index_value <= CHOP_MAX)
    else $error("index above the 200.0 ceiling");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE && !bar_i.ready)
    else $error("bar accepted but sequencer did not start");

  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> p_q >= PCW'(2) && p_q <= PCW'(MAX_PERIOD))
    else $error("scan running with a period outside 2..MAX_PERIOD");
endmodule

/* dv/choppiness_index_classifier_tb.sv */
// Self-checking testbench for the choppiness index classifier.
// Depends on cic_pkg, cic_bar_if, cic_res_if and the top level RTL.
`timescale 1ns / 1ps

module choppiness_index_classifier_tb;
  import cic_pkg::*;

  localparam int RING    = MAX_PERIOD_DEF;
  localparam int PW      = PRICE_WIDTH_DEF;
  localparam int SETTLE  = 400;   // settling cycles after the block has drained
  localparam int HOLDOFF = 2500;  // long receiver stall
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PW-1:0] high;
    logic [PW-1:0] low;
    logic [PW-1:0] close;
  } bar_t;

  typedef struct packed {
    logic          index_valid;
    logic [IDX_W-1:0] index_value;
    market_class_e market_class;
  } chop_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cic_bar_if bar_if ();
  cic_res_if res_if ();

  choppiness_index_classifier dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_i       (bar_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow configuration and window state of the block.
  logic [PERIOD_W-1:0] cfg_period;
  logic [THR_W-1:0]    cfg_choppy;
  logic [THR_W-1:0]    cfg_trending;

  logic [PW-1:0] last_close;
  int            bars_count;
  logic [63:0]   tr_ring [RING];
  logic [PW-1:0] hi_ring [RING];
  logic [PW-1:0] lo_ring [RING];
  int            wr_ptr;

  bar_t  bar_q[$];      // words waiting for the driver
  chop_t chop_q[$];     // index results still owed by the block
  int    errors;
  bit    calm;          // no idling on either side
  bit    hold_req;      // ask the receiver for one long stall
  logic  bar_fire;

  // log2 with 16 fraction bits by repeated squaring of a Q1.31 mantissa.
  function automatic logic [63:0] lg_q16(logic [63:0] x);
    int          n;
    logic [63:0] m;
    logic [63:0] frac;
    n = 0;
    frac = '0;
    if (x == 0) return '0;
    while (n < 63 && (x >> (n + 1)) != 0) n++;
    m = (n <= 31) ? (x << (31 - n)) : (x >> (n - 31));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(n) << LOG_FRAC) | frac;
  endfunction

  // Advance the shadow window by one bar and queue the index it yields.
  task automatic predict_chop(input bar_t b);
    logic [PW-1:0] top, bot, hmax, lmin;
    logic [63:0]   tr, sum, lp, chop;
    longint        d;
    int            p, idx;
    chop_t         r;
    tr = '0;
    if (bars_count > 0) begin
      top = (b.high > last_close) ? b.high : last_close;
      bot = (b.low < last_close) ? b.low : last_close;
      tr = 64'(top - bot);
    end
    tr_ring[wr_ptr] = tr;
    hi_ring[wr_ptr] = b.high;
    lo_ring[wr_ptr] = b.low;
    wr_ptr = (wr_ptr + 1) % RING;
    last_close = b.close;
    if (bars_count < RING + 1) bars_count++;

    p = int'(cfg_period);
    if (p < 2) p = 2;
    if (p > RING) p = RING;

    r = '{1'b0, '0, MC_NEUTRAL};
    if (bars_count >= p + 1) begin
      sum = '0;
      hmax = '0;
      lmin = '1;
      for (int k = 0; k < p; k++) begin
        idx = (wr_ptr + RING - 1 - k) % RING;
        sum += tr_ring[idx];
        if (hi_ring[idx] > hmax) hmax = hi_ring[idx];
        if (lo_ring[idx] < lmin) lmin = lo_ring[idx];
      end
      // flat window or no movement reads as the midpoint
      if (hmax <= lmin || sum == 0) begin
        chop = 64'(CHOP_HALF);
      end else begin
        d  = longint'(lg_q16(sum)) - longint'(lg_q16(64'(hmax - lmin)));
        lp = lg_q16(64'(p));
        if (d <= 0) begin
          chop = '0;
        end else begin
          chop = (64'(d) * 64'd25600 + lp / 2) / lp;
          if (chop > 64'(CHOP_MAX)) chop = 64'(CHOP_MAX);
        end
      end
      r.index_valid = 1'b1;
      r.index_value = chop[IDX_W-1:0];
      // choppy wins over trending when the thresholds overlap
      if (chop >= 64'(cfg_choppy)) r.market_class = MC_CHOPPY;
      else if (chop <= 64'(cfg_trending)) r.market_class = MC_TRENDING;
      else r.market_class = MC_TRANSITIONAL;
    end
    chop_q.insert(chop_q.size(), r);
  endtask

  // Track accepted bars at the rising edge and predict right away.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_fire <= 1'b0;
    end else begin
      bar_fire <= bar_if.valid && bar_if.ready;
      if (bar_if.valid && bar_if.ready)
        predict_chop('{bar_if.bar_high, bar_if.bar_low, bar_if.bar_close});
    end
  end

  // Driver: hold a word until taken, then load the next or idle.
  always @(negedge clk_i) begin
    if (rst_ni && (!bar_if.valid || bar_fire)) begin
      if (bar_q.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
        bar_if.valid     <= 1'b1;
        bar_if.bar_high  <= bar_q[0].high;
        bar_if.bar_low   <= bar_q[0].low;
        bar_if.bar_close <= bar_q[0].close;
        void'(bar_q.pop_front());
      end else begin
        bar_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request.
  int  hold_cnt;
  bit  hold_done;
  always @(negedge clk_i) begin
    if (hold_req && !hold_done && hold_cnt == 0) begin
      hold_cnt  = HOLDOFF;
      hold_done = 1'b1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  // Monitor: compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    chop_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (chop_q.size() == 0) begin
        $display("%0t: result with nothing expected: valid %0b value %0d class %0d",
                 $time, res_if.index_valid, res_if.index_value, res_if.market_class);
        errors++;
      end else begin
        e = chop_q.pop_front();
        if (res_if.index_valid !== e.index_valid) begin
          $display("%0t: index_valid expected %0b actual %0b",
                   $time, e.index_valid, res_if.index_valid);
          errors++;
        end
        if (res_if.index_value !== e.index_value) begin
          $display("%0t: index_value expected %0d actual %0d",
                   $time, e.index_value, res_if.index_value);
          errors++;
        end
        if (res_if.market_class !== e.market_class) begin
          $display("%0t: market_class expected %0d actual %0d",
                   $time, e.market_class, res_if.market_class);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_PERIOD:   cfg_period   = data[PERIOD_W-1:0];
      REG_CHOPPY:   cfg_choppy   = data;
      REG_TRENDING: cfg_trending = data;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold off the sender until the block has drained.
  task automatic drain();
    wait (bar_q.size() == 0 && !bar_if.valid && chop_q.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Random walk around a base price; mostly well-formed bars, some noise.
  logic [PW-1:0] walk;
  function automatic bar_t make_bar();
    bar_t b;
    int   sel;
    logic [PW-1:0] span;
    sel = $urandom_range(99);
    if (sel < 70) begin
      span = PW'($urandom_range(sel < 10 ? 0 : 4000));
      walk = walk + PW'($urandom_range(2000)) - PW'(1000);
      b.high  = walk + span;
      b.low   = walk;
      b.close = walk + PW'($urandom_range(int'(span)));
    end else if (sel < 85) begin
      b = '{$urandom, $urandom, $urandom};   // noise, often malformed
    end else if (sel < 92) begin
      b.low   = walk;
      b.high  = walk - PW'($urandom_range(50)); // low above high
      b.close = walk;
    end else begin
      b.high  = $urandom_range(1) ? '1 : PW'($urandom);
      b.low   = $urandom_range(1) ? '0 : PW'($urandom);
      b.close = $urandom_range(1) ? '1 : '0;
    end
    return b;
  endfunction

  // Append one word to the driver queue.
  task automatic put_bar(input bar_t b);
    bar_q.insert(bar_q.size(), b);
  endtask

  task automatic run_bars(input int count);
    repeat (count) put_bar(make_bar());
  endtask

  initial begin
    errors       = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    hold_cnt     = 0;
    hold_done    = 1'b0;
    cfg_period   = PERIOD_RST;
    cfg_choppy   = CHOPPY_RST;
    cfg_trending = TRENDING_RST;
    last_close   = '0;
    bars_count   = 0;
    wr_ptr       = 0;
    walk         = 32'd100000;
    cfg_we       = 1'b0;
    cfg_idx      = REG_PERIOD;
    cfg_wdata    = '0;
    bar_if.valid     = 1'b0;
    bar_if.bar_high  = '0;
    bar_if.bar_low   = '0;
    bar_if.bar_close = '0;
    res_if.ready     = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: flat window under the reset period, then field extremes.
    repeat (16) put_bar('{PW'(500), PW'(500), PW'(500)});
    put_bar('{'1, '0, '1});
    put_bar('{'0, '1, '0});
    put_bar('{'1, '1, '1});
    put_bar('{'0, '0, '0});
    put_bar('{PW'(10), PW'(20), PW'(15)});
    put_bar('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA});
    put_bar('{32'h5555_5555, 32'h0000_0001, 32'h8000_0000});
    drain();

    // Sweep settings: clamped periods, extreme and overlapping thresholds.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin cfg_write(REG_PERIOD, 16'd2);  cfg_write(REG_CHOPPY, 16'd0);
                 cfg_write(REG_TRENDING, 16'd0); end
        1: begin cfg_write(REG_PERIOD, 16'd64); cfg_write(REG_CHOPPY, CHOP_MAX);
                 cfg_write(REG_TRENDING, CHOP_MAX); end
        2: begin cfg_write(REG_PERIOD, 16'd0);  cfg_write(REG_CHOPPY, 16'hFFFF);
                 cfg_write(REG_TRENDING, 16'd0); end
        3: begin cfg_write(REG_PERIOD, 16'd1);  cfg_write(REG_CHOPPY, CHOPPY_RST);
                 cfg_write(REG_TRENDING, TRENDING_RST); end
        4: begin cfg_write(REG_PERIOD, 16'd127); cfg_write(REG_UNUSED, 16'hFFFF); end
        5: begin cfg_write(REG_PERIOD, 16'hFF85); cfg_write(REG_CHOPPY, 16'd9000);
                 cfg_write(REG_TRENDING, 16'd20000); end
        default: begin
          cfg_write(REG_PERIOD, 16'($urandom_range(2, 20)));
          cfg_write(REG_CHOPPY, 16'($urandom_range(51200)));
          cfg_write(REG_TRENDING, 16'($urandom_range(51200)));
        end
      endcase
      cfg_done();
      calm     = (ph == 6);
      hold_req = (ph == 7);
      run_bars((ph == 1 || ph == 4) ? 80 : 130);
      drain();
    end

    if (errors == 0) begin
      $display("choppiness_index_classifier_tb OK");
    end else begin
      $display("choppiness_index_classifier_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("choppiness_index_classifier_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cic_pkg.sv
hw/rtl/cic_bar_if.sv
hw/rtl/cic_res_if.sv
hw/rtl/cic_ram.sv
hw/rtl/cic_log2.sv
hw/rtl/choppiness_index_classifier.sv
dv/choppiness_index_classifier_tb.sv
